// ----- src/sha_pkg.sv -----
`timescale 1ns / 1ps

package sha_pkg;

    typedef logic [31:0] t_word;
    typedef logic [7:0][31:0] t_hash;

    // Control from the sequencer to the compression datapath
    typedef struct packed {
        logic       shift_en;   // shift one message byte into the schedule
        logic [7:0] byte_in;
        logic       init_en;    // load working vars from the hash words
        logic       round_en;   // run one round
        logic [5:0] round_idx;
    } t_comp_ctl;

    localparam t_hash HASH_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word round_k(input logic [5:0] t);
        unique case (t)
            6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
            default: round_k = 32'h0;
        endcase
    endfunction

endpackage

// ----- src/sha_ram.sv -----
`timescale 1ns / 1ps

module sha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/sha_comp.sv -----
`timescale 1ns / 1ps

module sha_comp (
    input  logic               i_clk,
    input  sha_pkg::t_comp_ctl i_ctl,
    input  sha_pkg::t_hash     i_hash,
    output sha_pkg::t_hash     o_vars
);

    // 16-word schedule window, word 0 in the top bits
    logic [511:0]   r_sched;
    sha_pkg::t_hash r_v;

    sha_pkg::t_word w0, w1, w9, w14, wt, s0, s1, t1, t2;
    sha_pkg::t_word a, b, c, d, e, f, g, h;

    always_comb begin
        w0  = r_sched[511 -: 32];
        w1  = r_sched[479 -: 32];
        w9  = r_sched[223 -: 32];
        w14 = r_sched[63 -: 32];
        s0  = sha_pkg::rotr(w1, 7) ^ sha_pkg::rotr(w1, 18) ^ (w1 >> 3);
        s1  = sha_pkg::rotr(w14, 17) ^ sha_pkg::rotr(w14, 19) ^ (w14 >> 10);
        wt  = (i_ctl.round_idx < 6'd16) ? w0 : (w0 + w9 + s0 + s1);
        a = r_v[0]; b = r_v[1]; c = r_v[2]; d = r_v[3];
        e = r_v[4]; f = r_v[5]; g = r_v[6]; h = r_v[7];
        t1 = h + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
               + (g ^ (e & (f ^ g))) + sha_pkg::round_k(i_ctl.round_idx) + wt;
        t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
               + ((a & b) ^ (a & c) ^ (b & c));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_en) begin
            r_sched <= {r_sched[503:0], i_ctl.byte_in};
        end else if (i_ctl.round_en) begin
            r_sched <= {r_sched[479:0], wt};
        end
        if (i_ctl.init_en) begin
            r_v <= i_hash;
        end else if (i_ctl.round_en) begin
            r_v <= {g, f, e, d + t1, c, b, a, t1 + t2};
        end
    end

    assign o_vars = r_v;

endmodule

// ----- src/sha256_hash_engine_core.sv -----
`timescale 1ns / 1ps

// SHA-256 byte-stream engine. Each request may restart the hash (tuser[1]), absorb
// one byte (tuser[0], byte in tdata) and ask for the digest (tuser[2]) of all bytes
// so far. A byte that does not close a 64-byte block is absorbed without leaving idle.
// Closing a block adds a compression: the block streams out of the byte RAM into the
// schedule window, 64 rounds run at one per cycle, and a final state does the chaining
// add. A digest request runs the padding on a copy of the state: one such
// compression, or two when 56 or more bytes sit in the open block. The chaining
// value, the byte count and the block buffer stay intact, so absorption goes on
// afterwards. The digest waits in an output register; new requests are taken while
// it waits, and a later digest stalls only its final add until the register frees.
module sha256_hash_engine_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  logic [2:0]   i_s_axis_tuser,   // [0] has_data, [1] first, [2] emit
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [255:0] o_m_axis_tdata    // digest_0, digest_1, digest_2, digest_3
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOAD  = 2'd1;
    localparam logic [1:0] ST_ROUND = 2'd2;
    localparam logic [1:0] ST_FINAL = 2'd3;

    logic [1:0]     r_state, n_state;
    logic [6:0]     r_cnt, n_cnt;
    logic [63:0]    r_count, n_count;
    sha_pkg::t_hash r_chain, n_chain;
    sha_pkg::t_hash r_hw, n_hw;
    logic           r_emit_mode, n_emit_mode;   // compressing a padded copy
    logic           r_blk1, n_blk1;             // second padding block
    logic           r_pend, n_pend;             // digest due after this block
    logic           r_ovalid, n_ovalid;
    logic [255:0]   r_out, n_out;

    logic           s_acc, m_acc;
    logic [63:0]    count_base;
    sha_pkg::t_hash chain_base, vars, sum;
    logic [7:0]     ram_rdata, pad_byte;
    logic [5:0]     lidx, fill;
    logic [63:0]    bits;
    logic           two_blk;
    sha_pkg::t_comp_ctl ctl;

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign m_acc = r_ovalid && i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_out;

    assign count_base = i_s_axis_tuser[1] ? 64'd0 : r_count;
    assign chain_base = i_s_axis_tuser[1] ? sha_pkg::HASH_IV : r_chain;

    // block buffer, written on absorb, streamed out during load
    sha_ram #(.WIDTH(8), .DEPTH(64)) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (s_acc && i_s_axis_tuser[0]),
        .i_waddr (count_base[5:0]),
        .i_wdata (i_s_axis_tdata),
        .i_raddr (r_cnt[5:0]),
        .o_rdata (ram_rdata)
    );

    sha_comp u_comp (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_hash (r_hw),
        .o_vars (vars)
    );

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            sum[i] = r_hw[i] + vars[i];
        end
    end

    // padding byte for the byte whose read data is arriving now
    assign lidx    = 6'(r_cnt - 7'd1);
    assign fill    = r_count[5:0];
    assign bits    = {r_count[60:0], 3'b000};
    assign two_blk = (fill >= 6'd56);

    always_comb begin
        pad_byte = 8'h00;
        if (!r_emit_mode) begin
            pad_byte = ram_rdata;
        end else if (!r_blk1) begin
            priority if (lidx < fill) begin
                pad_byte = ram_rdata;
            end else if (lidx == fill) begin
                pad_byte = sha_pkg::PAD_BYTE;
            end else if (!two_blk && lidx >= 6'd56) begin
                pad_byte = bits[8 * (7 - 32'(lidx[2:0])) +: 8];
            end else begin
                pad_byte = 8'h00;
            end
        end else if (lidx >= 6'd56) begin
            pad_byte = bits[8 * (7 - 32'(lidx[2:0])) +: 8];
        end
    end

    always_comb begin
        ctl.shift_en  = (r_state == ST_LOAD) && (r_cnt != 7'd0);
        ctl.byte_in   = pad_byte;
        ctl.init_en   = (r_state == ST_LOAD) && (r_cnt == 7'd64);
        ctl.round_en  = (r_state == ST_ROUND);
        ctl.round_idx = r_cnt[5:0];
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_count     = r_count;
        n_chain     = r_chain;
        n_hw        = r_hw;
        n_emit_mode = r_emit_mode;
        n_blk1      = r_blk1;
        n_pend      = r_pend;
        n_ovalid    = m_acc ? 1'b0 : r_ovalid;
        n_out       = r_out;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_chain = chain_base;
                    n_count = count_base;
                    n_hw    = chain_base;
                    n_cnt   = 7'd0;
                    n_blk1  = 1'b0;
                    if (i_s_axis_tuser[0]) begin
                        n_count = count_base + 64'd1;
                    end
                    if (i_s_axis_tuser[0] && count_base[5:0] == 6'd63) begin
                        // block closes: compress into the chaining value
                        n_state     = ST_LOAD;
                        n_emit_mode = 1'b0;
                        n_pend      = i_s_axis_tuser[2];
                    end else if (i_s_axis_tuser[2]) begin
                        n_state     = ST_LOAD;
                        n_emit_mode = 1'b1;
                        n_pend      = 1'b0;
                    end
                end
            end
            ST_LOAD: begin
                if (r_cnt == 7'd64) begin
                    n_state = ST_ROUND;
                    n_cnt   = 7'd0;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            ST_ROUND: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    n_state = ST_FINAL;
                    n_cnt   = 7'd0;
                end
            end
            ST_FINAL: begin
                if (!r_emit_mode) begin
                    n_chain = sum;
                    n_hw    = sum;
                    if (r_pend) begin
                        n_state     = ST_LOAD;
                        n_emit_mode = 1'b1;
                        n_blk1      = 1'b0;
                        n_pend      = 1'b0;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (!r_blk1 && two_blk) begin
                    n_hw    = sum;
                    n_blk1  = 1'b1;
                    n_state = ST_LOAD;
                end else if (!r_ovalid || i_m_axis_tready) begin
                    // digest word 0 lands in the top of digest_0
                    for (int k = 0; k < 4; k++) begin
                        n_out[64 * k +: 64] = {sum[2 * k], sum[2 * k + 1]};
                    end
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= 7'd0;
            r_count     <= 64'd0;
            r_chain     <= sha_pkg::HASH_IV;
            r_emit_mode <= 1'b0;
            r_blk1      <= 1'b0;
            r_pend      <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_count     <= n_count;
            r_chain     <= n_chain;
            r_emit_mode <= n_emit_mode;
            r_blk1      <= n_blk1;
            r_pend      <= n_pend;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hw  <= n_hw;
        r_out <= n_out;
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;    // [7:0] data_byte
    logic [2:0]   s_tuser;    // [0] has_data, [1] first, [2] emit
    logic         m_tvalid;
    logic         m_tready;
    logic [255:0] m_tdata;    // digest_0 .. digest_3 from the lowest bit up

    sha256_hash_engine_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata)
    );

    localparam int CYCLE_LIMIT = 4000000;

    // predictor state
    sha_pkg::t_word chain_h[8];
    logic [7:0]     blk_buf[64];
    logic [63:0]    byte_count;
    logic [255:0]   digest_q[$];

    int  errors = 0;
    int  cycles = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_recv = 0;

    function automatic sha_pkg::t_word rr(sha_pkg::t_word x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one compression of blk into h
    function automatic void sha_compress(ref sha_pkg::t_word h[8],
                                         input logic [7:0] blk[64]);
        sha_pkg::t_word w[16];
        sha_pkg::t_word v[8];
        sha_pkg::t_word s0, s1, t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        for (int t = 0; t < 8; t++) v[t] = h[t];
        for (int t = 0; t < 64; t++) begin
            if (t >= 16) begin
                s0 = rr(w[(t+1)%16], 7) ^ rr(w[(t+1)%16], 18) ^ (w[(t+1)%16] >> 3);
                s1 = rr(w[(t+14)%16], 17) ^ rr(w[(t+14)%16], 19) ^ (w[(t+14)%16] >> 10);
                w[t%16] = w[t%16] + w[(t+9)%16] + s0 + s1;
            end
            t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
                 + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + sha_pkg::round_k(t[5:0]) + w[t%16];
            t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++) h[t] = h[t] + v[t];
    endfunction

    function automatic void hash_restart();
        for (int k = 0; k < 8; k++) chain_h[k] = sha_pkg::HASH_IV[k];
        byte_count = '0;
    endfunction

    // digest of a padded copy; state stays untouched
    function automatic logic [255:0] padded_digest();
        sha_pkg::t_word h[8];
        logic [7:0]     pad[64];
        logic [63:0]    bits;
        int             fill;
        logic [255:0]   d;
        bits = byte_count << 3;
        fill = byte_count[5:0];
        h = chain_h;
        for (int k = 0; k < 64; k++) pad[k] = (k < fill) ? blk_buf[k] : 8'h00;
        pad[fill] = sha_pkg::PAD_BYTE;
        if (fill + 1 > 56) begin
            sha_compress(h, pad);
            for (int k = 0; k < 64; k++) pad[k] = 8'h00;
        end
        for (int k = 0; k < 8; k++) pad[56+k] = bits[63-8*k -: 8];
        sha_compress(h, pad);
        for (int k = 0; k < 4; k++) d[64*k +: 64] = {h[2*k], h[2*k+1]};
        return d;
    endfunction

    function automatic void predict(logic [7:0] b, logic has_data, logic first, logic emit);
        if (first) hash_restart();
        if (has_data) begin
            blk_buf[byte_count[5:0]] = b;
            byte_count = byte_count + 1;
            if (byte_count[5:0] == 0) sha_compress(chain_h, blk_buf);
        end
        if (emit) digest_q.push_back(padded_digest());
    endfunction

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver ready with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_recv)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // digest checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (digest_q.size() == 0) begin
                $display("%0t: digest with none expected, actual %h", $time, m_tdata);
                errors++;
            end else begin
                logic [255:0] want;
                want = digest_q.pop_front();
                for (int k = 0; k < 4; k++)
                    if (want[64*k +: 64] !== m_tdata[64*k +: 64]) begin
                        $display("%0t: digest_%0d expected %h actual %h",
                                 $time, k, want[64*k +: 64], m_tdata[64*k +: 64]);
                        errors++;
                    end
            end
        end
    end

    // send one request, then wait for acceptance; valid stays up until the
    // next request or an idle cycle replaces it
    task automatic send_req(logic [7:0] b, logic has_data, logic first, logic emit);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= {emit, first, has_data};
        do @(posedge i_clk); while (!s_tready);
        predict(b, has_data, first, emit);
    endtask

    // drop valid after the last request of a burst
    task automatic bus_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_bytes(int n, logic first, logic emit_end);
        for (int k = 0; k < n; k++)
            send_req(8'($urandom_range(255)), 1'b1, first && k == 0,
                     emit_end && k == n - 1);
    endtask

    // empty message, restarts, all-ones/zeros bytes, padding at 55/56/63/64 bytes
    task automatic test_directed();
        send_req(8'h00, 1'b0, 1'b0, 1'b1);       // empty digest after reset
        send_req(8'hff, 1'b1, 1'b1, 1'b1);       // restart with data
        send_req(8'h00, 1'b1, 1'b0, 1'b0);
        send_req(8'h5a, 1'b0, 1'b1, 1'b1);       // restart, no data -> empty digest
        send_req(8'ha5, 1'b0, 1'b0, 1'b0);       // ignored item
        send_bytes(55, 1'b1, 1'b1);              // one padding block
        send_req(8'h00, 1'b1, 1'b0, 1'b1);       // 56 bytes -> two padding blocks
        send_bytes(7, 1'b0, 1'b1);               // 63 bytes
        send_req(8'hff, 1'b1, 1'b0, 1'b1);       // full block
        send_req(8'h00, 1'b0, 1'b0, 1'b1);       // repeated emit
    endtask

    // mostly messages with random content, some noise items
    task automatic test_random(int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) < 8) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(70);
                for (int k = 0; k < len; k++)
                    send_req(8'($urandom_range(255)), 1'b1,
                             k == 0 && $urandom_range(3) != 0,
                             (k == len - 1) || ($urandom_range(15) == 0));
                sent += len;
            end else begin
                send_req(8'($urandom_range(255)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    // receiver holds off while the sender keeps pushing digest requests
    task automatic test_backpressure();
        fork
            begin
                hold_recv = 1;
                repeat (3000) @(posedge i_clk);
                hold_recv = 0;
            end
            begin
                for (int k = 0; k < 12; k++)
                    send_req(8'($urandom_range(255)), 1'b1, 1'b0, 1'b1);
                bus_idle();
            end
        join
    endtask

    initial begin
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        hash_restart();
        for (int k = 0; k < 64; k++) blk_buf[k] = 8'h00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        send_idle_pct = 27; recv_idle_pct = 85;
        test_random(600);
        test_backpressure();
        send_idle_pct = 85; recv_idle_pct = 27;
        test_random(600);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(600);
        bus_idle();

        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ----- sha256_hash_engine_core.f -----
src/sha_pkg.sv
src/sha_ram.sv
src/sha_comp.sv
src/sha256_hash_engine_core.sv
dv/testbench.sv
